// File: hw/rtl/sfau_pkg.sv
// ----------------------------------------------------------------------------
// sfau_pkg
// Shared types, command codes and packing helpers of the single-precision unit.
// ----------------------------------------------------------------------------
package sfau_pkg;

  typedef enum logic [3:0] {
    CMD_ADD = 4'd0,
    CMD_SUB = 4'd1,
    CMD_MUL = 4'd2,
    CMD_DIV = 4'd3,
    CMD_I2F = 4'd4,
    CMD_U2F = 4'd5,
    CMD_F2I = 4'd6,
    CMD_F2D = 4'd7,
    CMD_D2F = 4'd8,
    CMD_EQ  = 4'd9,
    CMD_LT  = 4'd10,
    CMD_LE  = 4'd11,
    CMD_GT  = 4'd12,
    CMD_GE  = 4'd13
  } cmd_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SETUP,
    ST_EXEC,
    ST_DNORM,
    ST_DIV,
    ST_NORM,
    ST_PACK,
    ST_OUT
  } state_t;

  // Signed working exponent, wide enough for every intermediate value.
  typedef logic signed [12:0] exp_t;

  localparam logic [22:0] FRAC_MASK  = 23'h7FFFFF;
  localparam logic [31:0] INT_MAX    = 32'h7FFFFFFF;
  localparam logic [31:0] INT_MIN    = 32'h80000000;
  localparam int          BIAS_S     = 127;
  localparam int          BIAS_D     = 1023;
  localparam int          DIV_QBITS  = 26;

  // Truncating single pack: flush below range, infinity above.
  function automatic logic [31:0] pack_single(input logic s, input exp_t e,
                                              input logic [23:0] m);
    logic [31:0] res;
    if (m == 24'd0 || e < 13'sd1) begin
      res = {s, 31'd0};
    end else if (e >= 13'sd255) begin
      res = {s, 8'hFF, 23'd0};
    end else begin
      res = {s, e[7:0], m[22:0] & FRAC_MASK};
    end
    return res;
  endfunction

endpackage

// File: hw/rtl/sfau_if.sv
// ----------------------------------------------------------------------------
// sfau_if
// Ready/valid channels of the single-precision unit: command and result.
// ----------------------------------------------------------------------------
interface sfau_in_if import sfau_pkg::*; ();
  logic        valid;
  logic        ready;
  logic [3:0]  cmd;
  logic [63:0] operand_a;
  logic [31:0] operand_b;

  modport source (output valid, output cmd, output operand_a, output operand_b,
                  input ready);
  modport sink   (input valid, input cmd, input operand_a, input operand_b,
                  output ready);
endinterface

interface sfau_out_if import sfau_pkg::*; ();
  logic        valid;
  logic        ready;
  logic [63:0] result;

  modport source (output valid, output result, input ready);
  modport sink   (input valid, input result, output ready);
endinterface

// File: hw/rtl/sfau_div.sv
// ----------------------------------------------------------------------------
// sfau_div
// Restoring mantissa divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module sfau_div import sfau_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  input  logic [23:0]          num,
  input  logic [23:0]          den,
  output logic                 done,
  output logic [DIV_QBITS-1:0] quo
);

  logic [24:0]          rem_r, rem_nxt;
  logic [23:0]          den_r, den_nxt;
  logic [DIV_QBITS-1:0] q_r, q_nxt;
  logic [4:0]           cnt_r, cnt_nxt;
  logic                 done_r, done_nxt;
  logic                 ge;
  logic [24:0]          diff;

  always_comb begin
    ge       = (rem_r >= {1'b0, den_r});
    diff     = ge ? (rem_r - {1'b0, den_r}) : rem_r;
    rem_nxt  = rem_r;
    den_nxt  = den_r;
    q_nxt    = q_r;
    cnt_nxt  = cnt_r;
    done_nxt = 1'b0;
    if (start) begin
      rem_nxt = {1'b0, num};
      den_nxt = den;
      q_nxt   = '0;
      cnt_nxt = 5'(DIV_QBITS);
    end else if (cnt_r != 5'd0) begin
      // remainder stays below den, so the shift fits
      rem_nxt  = {diff[23:0], 1'b0};
      q_nxt    = {q_r[DIV_QBITS-2:0], ge};
      cnt_nxt  = cnt_r - 5'd1;
      done_nxt = (cnt_r == 5'd1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      done_r <= 1'b0;
    end else begin
      cnt_r  <= cnt_nxt;
      done_r <= done_nxt;
    end
    rem_r <= rem_nxt;
    den_r <= den_nxt;
    q_r   <= q_nxt;
  end

  assign done = done_r;
  assign quo  = q_r;

endmodule

// File: hw/rtl/single_float_arith_unit.sv
// ----------------------------------------------------------------------------
// single_float_arith_unit
// Truncating single-precision unit: add, sub, mul, div, conversions, compares.
// ----------------------------------------------------------------------------
// Compares and direct conversions go from setup straight to out_ch.valid;
// add/sub, mul, i2f/u2f and subnormal f2d normalize one bit at a time and
// pack; div pre-shifts its operands and runs the divider before that.
// One item at a time: in_ch.ready is high only when idle, entered in the cycle
// after the result is taken.
// Synchronous active-low reset returns the sequencer and divider to idle.
// ----------------------------------------------------------------------------
module single_float_arith_unit import sfau_pkg::*; (
  input  logic         clk,
  input  logic         rst_n,
  sfau_in_if.sink      in_ch,
  sfau_out_if.source   out_ch
);

  // sequencer
  state_t state_r, state_nxt;

  // captured item
  logic [3:0]  cmd_r, cmd_nxt;
  logic [63:0] a_r, a_nxt;
  logic [31:0] b_r, b_nxt;

  // working datapath registers
  logic        s_r, s_nxt;
  exp_t        e_r, e_nxt;
  exp_t        eb_r, eb_nxt;
  logic [23:0] ma_r, ma_nxt;
  logic [23:0] mb_r, mb_nxt;
  logic [56:0] r_r, r_nxt;       // wide mantissa / aligned addend
  logic        same_r, same_nxt; // effective add when signs agree
  logic        dbl_r, dbl_nxt;   // pack as double (subnormal f2d)
  logic [63:0] res_r, res_nxt;

  // control flags for the sequencer
  logic setup_direct, setup_norm, setup_exec, setup_dnorm;
  logic sum_zero, dn_ready;
  logic div_start, div_done;
  logic [DIV_QBITS-1:0] div_q;

  // setup-stage temporaries
  logic [31:0] ua, ub;
  logic        usa, usb, sbig, ssml;
  exp_t        uea, ueb, ebig, esml;
  logic [23:0] uma, umb, mbig, msml;
  logic        swap;
  logic [7:0]  dsh;
  logic [55:0] wfull, wsh, wb;
  logic        lost;
  logic signed [32:0] ka, kb;
  logic [31:0] mag;
  exp_t        fe;
  logic [31:0] m32;
  exp_t        ed;
  logic [56:0] sum;
  logic [47:0] prod;
  exp_t        qe;
  logic [23:0] qm;

  sfau_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (ma_r),
    .den   (mb_r),
    .done  (div_done),
    .quo   (div_q)
  );

  // ---------------------------------------------------------------- datapath
  always_comb begin
    cmd_nxt  = cmd_r;
    a_nxt    = a_r;
    b_nxt    = b_r;
    s_nxt    = s_r;
    e_nxt    = e_r;
    eb_nxt   = eb_r;
    ma_nxt   = ma_r;
    mb_nxt   = mb_r;
    r_nxt    = r_r;
    same_nxt = same_r;
    dbl_nxt  = dbl_r;
    res_nxt  = res_r;

    setup_direct = 1'b0;
    setup_norm   = 1'b0;
    setup_exec   = 1'b0;
    setup_dnorm  = 1'b0;

    // unpack both singles; subtraction flips b's sign
    ua  = a_r[31:0];
    ub  = (cmd_r == CMD_SUB) ? (b_r ^ INT_MIN) : b_r;
    usa = ua[31];
    usb = ub[31];
    uea = (ua[30:23] == 8'd0) ? 13'sd1 : exp_t'({5'd0, ua[30:23]});
    ueb = (ub[30:23] == 8'd0) ? 13'sd1 : exp_t'({5'd0, ub[30:23]});
    uma = {ua[30:23] != 8'd0, ua[22:0]};
    umb = {ub[30:23] != 8'd0, ub[22:0]};

    // magnitude ordering for add/sub
    swap = (uea < ueb) || ((uea == ueb) && (uma < umb));
    sbig = swap ? usb : usa;
    ssml = swap ? usa : usb;
    ebig = swap ? ueb : uea;
    esml = swap ? uea : ueb;
    mbig = swap ? umb : uma;
    msml = swap ? uma : umb;
    dsh  = 8'(ebig - esml);

    // align smaller addend with sticky bit
    wfull = {msml, 32'd0};
    wsh   = wfull >> dsh[5:0];
    lost  = ((wsh << dsh[5:0]) != wfull);
    if (msml == 24'd0)      wb = '0;
    else if (dsh >= 8'd56)  wb = 56'd1;
    else                    wb = wsh | {55'd0, lost};

    // compare keys: signed magnitude
    ka = a_r[31] ? -$signed({2'b0, a_r[30:0]}) : $signed({2'b0, a_r[30:0]});
    kb = b_r[31] ? -$signed({2'b0, b_r[30:0]}) : $signed({2'b0, b_r[30:0]});

    mag = (cmd_r == CMD_I2F && a_r[31]) ? (~a_r[31:0] + 32'd1) : a_r[31:0];

    // float to int
    fe  = exp_t'({5'd0, a_r[30:23]}) - 13'sd127;
    m32 = {8'd0, 1'b1, a_r[22:0]};
    if (fe <= 13'sd23) m32 = m32 >> 5'(13'sd23 - fe);
    else               m32 = m32 << 5'(fe - 13'sd23);
    if (a_r[31]) m32 = ~m32 + 32'd1;

    ed = exp_t'({2'b0, a_r[62:52]}) - 13'sd896;

    sum  = same_r ? ({1'b0, ma_r, 32'd0} + {1'b0, r_r[55:0]})
                  : ({1'b0, ma_r, 32'd0} - {1'b0, r_r[55:0]});
    prod = ma_r * mb_r;
    sum_zero = (sum == 57'd0);
    dn_ready = ma_r[23] && mb_r[23];

    qe = div_q[DIV_QBITS-1] ? (e_r - eb_r + 13'sd127) : (e_r - eb_r + 13'sd126);
    qm = div_q[DIV_QBITS-1] ? div_q[25:2] : div_q[24:1];

    unique case (state_r)
      ST_IDLE: begin
        if (in_ch.valid) begin
          cmd_nxt = in_ch.cmd;
          a_nxt   = in_ch.operand_a;
          b_nxt   = in_ch.operand_b;
          dbl_nxt = 1'b0;
        end
      end

      ST_SETUP: begin
        res_nxt = '0;
        case (cmd_r)
          CMD_ADD, CMD_SUB: begin
            if (mbig == 24'd0) begin
              setup_direct = 1'b1;
              res_nxt = {32'd0, (sbig == ssml) ? sbig : 1'b0, 31'd0};
            end else begin
              setup_exec = 1'b1;
              s_nxt    = sbig;
              e_nxt    = ebig;
              ma_nxt   = mbig;
              r_nxt    = {1'b0, wb};
              same_nxt = (sbig == ssml);
            end
          end
          CMD_MUL: begin
            if (uma == 24'd0 || umb == 24'd0) begin
              setup_direct = 1'b1;
              res_nxt = {32'd0, usa ^ usb, 31'd0};
            end else begin
              setup_exec = 1'b1;
              s_nxt  = usa ^ usb;
              e_nxt  = uea + ueb - 13'sd126;
              ma_nxt = uma;
              mb_nxt = umb;
            end
          end
          CMD_DIV: begin
            if (umb == 24'd0) begin
              setup_direct = 1'b1;
              res_nxt = {32'd0, usa ^ usb, 8'hFF, 23'd0};
            end else if (uma == 24'd0) begin
              setup_direct = 1'b1;
              res_nxt = {32'd0, usa ^ usb, 31'd0};
            end else begin
              setup_dnorm = 1'b1;
              s_nxt  = usa ^ usb;
              e_nxt  = uea;
              eb_nxt = ueb;
              ma_nxt = uma;
              mb_nxt = umb;
            end
          end
          CMD_I2F, CMD_U2F: begin
            if (mag == 32'd0) begin
              setup_direct = 1'b1;
            end else begin
              setup_norm = 1'b1;
              s_nxt = (cmd_r == CMD_I2F) && a_r[31];
              e_nxt = 13'sd158;
              r_nxt = {1'b0, mag, 24'd0};
            end
          end
          CMD_F2I: begin
            setup_direct = 1'b1;
            if (fe < 13'sd0)       res_nxt = '0;
            else if (fe > 13'sd30) res_nxt = {32'd0, a_r[31] ? INT_MIN : INT_MAX};
            else                   res_nxt = {32'd0, m32};
          end
          CMD_F2D: begin
            if (a_r[30:23] == 8'hFF) begin
              setup_direct = 1'b1;
              res_nxt = {a_r[31], 11'h7FF, a_r[22:0], 29'd0};
            end else if (a_r[30:23] == 8'd0 && a_r[22:0] == 23'd0) begin
              setup_direct = 1'b1;
              res_nxt = {a_r[31], 63'd0};
            end else if (a_r[30:23] == 8'd0) begin
              // subnormal: normalize then pack as double
              setup_norm = 1'b1;
              dbl_nxt = 1'b1;
              s_nxt   = a_r[31];
              e_nxt   = 13'sd1;
              r_nxt   = {2'b0, a_r[22:0], 32'd0};
            end else begin
              setup_direct = 1'b1;
              res_nxt = {a_r[31], 11'({3'd0, a_r[30:23]} + 11'd896), a_r[22:0], 29'd0};
            end
          end
          CMD_D2F: begin
            setup_direct = 1'b1;
            if (a_r[62:52] == 11'd0)
              res_nxt = {32'd0, a_r[63], 31'd0};
            else if (a_r[62:52] == 11'h7FF)
              res_nxt = {32'd0, a_r[63], 8'hFF, a_r[51:29]};
            else
              res_nxt = {32'd0, pack_single(a_r[63], ed, {1'b1, a_r[51:29]})};
          end
          CMD_EQ: begin setup_direct = 1'b1; res_nxt = {63'd0, ka == kb}; end
          CMD_LT: begin setup_direct = 1'b1; res_nxt = {63'd0, ka <  kb}; end
          CMD_LE: begin setup_direct = 1'b1; res_nxt = {63'd0, ka <= kb}; end
          CMD_GT: begin setup_direct = 1'b1; res_nxt = {63'd0, ka >  kb}; end
          CMD_GE: begin setup_direct = 1'b1; res_nxt = {63'd0, ka >= kb}; end
          default: begin setup_direct = 1'b1; end
        endcase
      end

      ST_EXEC: begin
        if (cmd_r == CMD_MUL) begin
          r_nxt = {1'b0, prod, 8'd0};
        end else if (sum_zero) begin
          res_nxt = '0;
        end else if (sum[56]) begin
          r_nxt = {1'b0, sum[56:1]};
          e_nxt = e_r + 13'sd1;
        end else begin
          r_nxt = sum;
        end
      end

      ST_DNORM: begin
        if (!ma_r[23]) begin
          ma_nxt = {ma_r[22:0], 1'b0};
          e_nxt  = e_r - 13'sd1;
        end
        if (!mb_r[23]) begin
          mb_nxt = {mb_r[22:0], 1'b0};
          eb_nxt = eb_r - 13'sd1;
        end
      end

      ST_DIV: begin
        if (div_done) begin
          r_nxt = {1'b0, qm, 32'd0};
          e_nxt = qe;
        end
      end

      ST_NORM: begin
        // one bit per cycle until the leading one reaches bit 55
        if (!r_r[55]) begin
          r_nxt = {r_r[55:0], 1'b0};
          e_nxt = e_r - 13'sd1;
        end
      end

      ST_PACK: begin
        if (dbl_r) res_nxt = {s_r, 11'(e_r + 13'sd896), r_r[54:32], 29'd0};
        else       res_nxt = {32'd0, pack_single(s_r, e_r, r_r[55:32])};
      end

      ST_OUT: begin
      end

      default: begin
      end
    endcase
  end

  // -------------------------------------------------------------- next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE:  if (in_ch.valid) state_nxt = ST_SETUP;
      ST_SETUP: begin
        if (setup_exec)       state_nxt = ST_EXEC;
        else if (setup_dnorm) state_nxt = ST_DNORM;
        else if (setup_norm)  state_nxt = ST_NORM;
        else                  state_nxt = ST_OUT;
      end
      ST_EXEC: begin
        if (cmd_r != CMD_MUL && sum_zero) state_nxt = ST_OUT;
        else                              state_nxt = ST_NORM;
      end
      ST_DNORM: if (dn_ready) state_nxt = ST_DIV;
      ST_DIV:   if (div_done) state_nxt = ST_NORM;
      ST_NORM:  if (r_r[55])  state_nxt = ST_PACK;
      ST_PACK:  state_nxt = ST_OUT;
      ST_OUT:   if (out_ch.ready) state_nxt = ST_IDLE;
      default:  state_nxt = ST_IDLE;
    endcase
  end

  // ----------------------------------------------------------------- outputs
  always_comb begin
    in_ch.ready  = (state_r == ST_IDLE);
    out_ch.valid = (state_r == ST_OUT);
    out_ch.result = res_r;
    div_start    = (state_r == ST_DNORM) && dn_ready;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
    cmd_r  <= cmd_nxt;
    a_r    <= a_nxt;
    b_r    <= b_nxt;
    s_r    <= s_nxt;
    e_r    <= e_nxt;
    eb_r   <= eb_nxt;
    ma_r   <= ma_nxt;
    mb_r   <= mb_nxt;
    r_r    <= r_nxt;
    same_r <= same_nxt;
    dbl_r  <= dbl_nxt;
    res_r  <= res_nxt;
  end

  // -------------------------------------------------------------- assertions
  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_ch.ready && out_ch.valid))
    else $error("input and output handshakes overlap");

  a_div_done_in_div: assert property (@(posedge clk) disable iff (!rst_n)
    div_done |-> (state_r == ST_DIV))
    else $error("divider finished outside divide wait");

  a_norm_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_NORM) |-> (r_r != 57'd0))
    else $error("normalize loop entered with zero mantissa");

  a_start_then_wait: assert property (@(posedge clk) disable iff (!rst_n)
    div_start |=> (state_r == ST_DIV))
    else $error("divider started without entering divide wait");

endmodule

// File: test/single_float_arith_unit_tb.sv
// ----------------------------------------------------------------------------
// single_float_arith_unit_tb
// Self-checking bench for the truncating single-precision unit. A queue of
// commands feeds a ready/valid driver; a monitor compares each result word
// with a software prediction of the add/sub/mul/div, conversion and compare
// paths and of the unused command codes, in order.
// ----------------------------------------------------------------------------
module single_float_arith_unit_tb import sfau_pkg::*; ;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [3:0]  cmd;
    logic [63:0] opa;
    logic [31:0] opb;
  } fpu_op_t;

  localparam int CYCLE_LIMIT = 400000;
  localparam int DRAIN_WAIT  = 80;
  localparam logic [3:0] CMD_BAD_LO = 4'd14;
  localparam logic [3:0] CMD_BAD_HI = 4'd15;

  logic clk;
  logic rst_n;

  sfau_in_if  in_ch ();
  sfau_out_if out_ch ();

  single_float_arith_unit DUT (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch.sink),
    .out_ch (out_ch.source)
  );

  // Stimulus and expected-result stores
  fpu_op_t     op_queue[$];
  logic [63:0] result_queue[$];
  int          mismatches;
  int          cycle_count;

  // Idle shaping: percentage of cycles each side idles
  int src_idle_pct;
  int snk_idle_pct;
  int hold_cycles;       // long receiver stall, counted in its own process
  bit hold_request;

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // ---------------------------------------------------------------- predictor
  function automatic logic [31:0] fp_pack(logic s, int e, logic [63:0] m);
    if (m == 0 || e < 1) return {s, 31'd0};
    if (e >= 255) return {s, 8'hFF, 23'd0};
    return {s, e[7:0], m[22:0]};
  endfunction

  // Split into sign, exponent and significand; subnormals keep e = 1.
  function automatic void fp_split(logic [31:0] f, output logic s, output int e,
                                   output logic [23:0] m);
    s = f[31];
    e = f[30:23];
    m = {1'b0, f[22:0]};
    if (e == 0) e = 1;
    else m[23] = 1'b1;
  endfunction

  function automatic logic [31:0] fp_add(logic [31:0] a, logic [31:0] b);
    logic sa, sb, ts;
    int ea, eb, te, d, e;
    logic [23:0] ma, mb, tm;
    logic [63:0] wa, wb, r;
    logic lost;
    fp_split(a, sa, ea, ma);
    fp_split(b, sb, eb, mb);
    // order by magnitude so the subtraction never goes negative
    if (ea < eb || (ea == eb && ma < mb)) begin
      ts = sa; sa = sb; sb = ts;
      te = ea; ea = eb; eb = te;
      tm = ma; ma = mb; mb = tm;
    end
    if (ma == 0) return (sa == sb) ? {sa, 31'd0} : 32'd0;
    d = ea - eb;
    wa = {8'd0, ma, 32'd0};
    if (mb == 0) wb = 0;
    else if (d >= 56) wb = 64'd1;
    else begin
      wb = {8'd0, mb, 32'd0};
      lost = (wb & ((64'd1 << d) - 64'd1)) != 0;  // sticky bit
      wb = wb >> d;
      if (lost) wb[0] = 1'b1;
    end
    r = (sa == sb) ? wa + wb : wa - wb;
    if (r == 0) return 32'd0;
    e = ea;
    if (r[63:56] != 0) begin
      r = r >> 1;
      e++;
    end
    while (!r[55]) begin
      r = r << 1;
      e--;
    end
    return fp_pack(sa, e, r >> 32);
  endfunction

  function automatic logic [31:0] fp_mul(logic [31:0] a, logic [31:0] b);
    logic sa, sb;
    int ea, eb, e;
    logic [23:0] ma, mb;
    logic [63:0] p;
    fp_split(a, sa, ea, ma);
    fp_split(b, sb, eb, mb);
    if (ma == 0 || mb == 0) return {sa ^ sb, 31'd0};
    p = 64'(ma) * 64'(mb);
    e = ea + eb - 126;
    while (!p[47]) begin
      p = p << 1;
      e--;
    end
    return fp_pack(sa ^ sb, e, p >> 24);
  endfunction

  function automatic logic [31:0] fp_div(logic [31:0] a, logic [31:0] b);
    logic sa, sb;
    int ea, eb;
    logic [23:0] ma, mb;
    logic [63:0] q;
    fp_split(a, sa, ea, ma);
    fp_split(b, sb, eb, mb);
    if (mb == 0) return {sa ^ sb, 8'hFF, 23'd0};
    if (ma == 0) return {sa ^ sb, 31'd0};
    while (!ma[23]) begin
      ma = ma << 1;
      ea--;
    end
    while (!mb[23]) begin
      mb = mb << 1;
      eb--;
    end
    q = (64'(ma) << 25) / 64'(mb);
    if (q[63:25] != 0) return fp_pack(sa ^ sb, ea - eb + 127, q >> 2);
    return fp_pack(sa ^ sb, ea - eb + 126, q >> 1);
  endfunction

  function automatic logic [31:0] fp_from_int(logic s, logic [31:0] mag);
    int p;
    logic [63:0] m;
    if (mag == 0) return 32'd0;
    p = 31;
    while (!mag[p]) p--;
    if (p > 23) m = 64'(mag >> (p - 23));
    else m = 64'(mag) << (23 - p);
    return fp_pack(s, 127 + p, m);
  endfunction

  function automatic logic [31:0] fp_to_int(logic [31:0] f);
    int e;
    logic [31:0] m;
    e = int'(f[30:23]) - 127;
    if (e < 0) return 32'd0;
    if (e > 30) return f[31] ? INT_MIN : INT_MAX;
    m = {9'd1, f[22:0]};
    if (e <= 23) m = m >> (23 - e);
    else m = m << (e - 23);
    if (f[31]) m = ~m + 32'd1;
    return m;
  endfunction

  function automatic logic [63:0] fp_widen(logic [31:0] f);
    logic [22:0] m;
    logic [23:0] mw;
    int e;
    logic [10:0] ed;
    if (f[30:23] == 8'hFF) return {f[31], 11'h7FF, f[22:0], 29'd0};
    if (f[30:23] == 0) begin
      if (f[22:0] == 0) return {f[31], 63'd0};
      e = 1;
      mw = {1'b0, f[22:0]};
      while (!mw[23]) begin
        mw = mw << 1;
        e--;
      end
      m = mw[22:0];
    end else begin
      e = f[30:23];
      m = f[22:0];
    end
    ed = 11'(e - BIAS_S + BIAS_D);
    return {f[31], ed, m, 29'd0};
  endfunction

  function automatic logic [31:0] fp_narrow(logic [63:0] d);
    int ed;
    ed = d[62:52];
    if (ed == 0) return {d[63], 31'd0};
    if (ed == 'h7FF) return {d[63], 8'hFF, d[51:29]};
    return fp_pack(d[63], ed - BIAS_D + BIAS_S, {40'd0, 1'b1, d[51:29]});
  endfunction

  function automatic longint fp_order(logic [31:0] f);
    longint mag;
    mag = longint'(f[30:0]);
    return f[31] ? -mag : mag;
  endfunction

  function automatic logic [63:0] fpu_predict(fpu_op_t op);
    logic [31:0] a, b;
    longint ka, kb;
    a = op.opa[31:0];
    b = op.opb;
    ka = fp_order(a);
    kb = fp_order(b);
    case (op.cmd)
      CMD_ADD: return {32'd0, fp_add(a, b)};
      CMD_SUB: return {32'd0, fp_add(a, b ^ 32'h80000000)};
      CMD_MUL: return {32'd0, fp_mul(a, b)};
      CMD_DIV: return {32'd0, fp_div(a, b)};
      CMD_I2F: return {32'd0, a[31] ? fp_from_int(1'b1, ~a + 32'd1) : fp_from_int(1'b0, a)};
      CMD_U2F: return {32'd0, fp_from_int(1'b0, a)};
      CMD_F2I: return {32'd0, fp_to_int(a)};
      CMD_F2D: return fp_widen(a);
      CMD_D2F: return {32'd0, fp_narrow(op.opa)};
      CMD_EQ:  return 64'(ka == kb);
      CMD_LT:  return 64'(ka < kb);
      CMD_LE:  return 64'(ka <= kb);
      CMD_GT:  return 64'(ka > kb);
      CMD_GE:  return 64'(ka >= kb);
      default: return 64'd0;
    endcase
  endfunction

  // ----------------------------------------------------------------- stimulus
  function automatic logic [31:0] rand_single();
    logic [31:0] f;
    f = $urandom;
    case ($urandom_range(0, 9))
      0: f[30:23] = 8'd0;                          // zero / subnormal
      1: f[30:23] = 8'hFF;                         // all-ones exponent
      2: f[30:23] = 8'(($urandom_range(0, 1)) ? $urandom_range(1, 8)
                                             : $urandom_range(246, 254));
      3: f[22:0] = 23'd0;
      default: f[30:23] = 8'($urandom_range(100, 154));
    endcase
    if ($urandom_range(0, 19) == 0) f[30:0] = 31'd0;
    return f;
  endfunction

  task automatic add_op(logic [3:0] c, logic [63:0] a, logic [31:0] b);
    fpu_op_t op;
    op.cmd = c;
    op.opa = a;
    op.opb = b;
    op_queue.push_back(op);
  endtask

  task automatic add_random_ops(int n);
    logic [63:0] a;
    logic [31:0] b;
    logic [3:0] c;
    for (int i = 0; i < n; i++) begin
      c = ($urandom_range(0, 49) == 0) ? 4'($urandom_range(14, 15))
                                       : 4'($urandom_range(0, 13));
      a = {$urandom, rand_single()};
      b = rand_single();
      // compares often see equal magnitudes or an opposite-signed copy
      if ($urandom_range(0, 3) == 0) b = a[31:0] ^ {$urandom_range(0, 1) == 1, 31'd0};
      if (c == CMD_I2F || c == CMD_U2F) a[31:0] = $urandom >> $urandom_range(0, 31);
      if (c == CMD_D2F) begin
        case ($urandom_range(0, 5))
          0: a[62:52] = 11'd0;
          1: a[62:52] = 11'h7FF;
          2: a[62:52] = 11'($urandom_range(850, 1200));
          default: a[62:52] = 11'($urandom_range(1000, 1050));
        endcase
      end
      add_op(c, a, b);
    end
  endtask

  // Wait for every queued item to leave and every result to come back.
  task automatic wait_drained();
    while (op_queue.size() != 0 || result_queue.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
  endtask

  // ------------------------------------------------------------------- driver
  // Holds each item until accepted; a new item can follow directly unless the source idles.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_ch.valid     <= 1'b0;
      in_ch.cmd       <= CMD_ADD;
      in_ch.operand_a <= 64'd0;
      in_ch.operand_b <= 32'd0;
    end else begin
      automatic bit fire = in_ch.valid && in_ch.ready;
      if (fire) result_queue.push_back(fpu_predict(op_queue.pop_front()));
      if ((!in_ch.valid || fire) && op_queue.size() != 0 &&
          $urandom_range(0, 99) >= src_idle_pct) begin
        in_ch.valid     <= 1'b1;
        in_ch.cmd       <= op_queue[0].cmd;
        in_ch.operand_a <= op_queue[0].opa;
        in_ch.operand_b <= op_queue[0].opb;
      end else if (fire) begin
        in_ch.valid <= 1'b0;
      end
    end
  end

  // ------------------------------------------------------------ receiver hold
  // Counts down a long stall once requested.
  always @(posedge clk) begin
    if (!rst_n) begin
      hold_cycles <= 0;
    end else if (hold_request && hold_cycles == 0) begin
      hold_cycles <= 400;
    end else if (hold_cycles > 0) begin
      hold_cycles <= hold_cycles - 1;
    end
  end

  // ------------------------------------------------------------------ monitor
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        if (result_queue.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected result %h", out_ch.result);
        end else begin
          automatic logic [63:0] want = result_queue.pop_front();
          if (out_ch.result !== want) begin
            mismatches++;
            if (mismatches <= 10)
              $display("result mismatch: expected %h actual %h", want, out_ch.result);
          end
        end
      end
      // long receiver stall while the sender keeps offering items
      if (hold_request || hold_cycles != 0) begin
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= ($urandom_range(0, 99) >= snk_idle_pct);
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // --------------------------------------------------------------- sequencing
  initial begin
    rst_n        = 1'b0;
    mismatches   = 0;
    cycle_count  = 0;
    src_idle_pct = 12;
    snk_idle_pct = 46;
    hold_request = 1'b0;
    in_ch.valid     = 1'b0;
    in_ch.cmd       = CMD_ADD;
    in_ch.operand_a = 64'd0;
    in_ch.operand_b = 32'd0;
    out_ch.ready    = 1'b0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // directed: every command plus the special cases
    add_op(CMD_ADD, 64'h3F800000, 32'hBF800000);        // x + (-x) gives +0
    add_op(CMD_ADD, 64'h80000000, 32'h80000000);        // -0 + -0 keeps sign
    add_op(CMD_ADD, 64'h7F7FFFFF, 32'h7F7FFFFF);        // overflow to infinity
    add_op(CMD_SUB, 64'h00800000, 32'h00400000);        // into subnormal range
    add_op(CMD_SUB, 64'h3F800001, 32'h3F800000);
    add_op(CMD_MUL, 64'h80000000, 32'h3F800000);        // signed zero product
    add_op(CMD_MUL, 64'h00800000, 32'h00800000);        // underflow flush
    add_op(CMD_MUL, 64'h00000001, 32'h7F7FFFFF);        // subnormal operand
    add_op(CMD_DIV, 64'h3F800000, 32'h80000000);        // divide by zero
    add_op(CMD_DIV, 64'h00000000, 32'h00000000);        // 0/0 gives infinity
    add_op(CMD_DIV, 64'h00000003, 32'h7F800000);
    add_op(CMD_I2F, 64'h80000000, 32'd0);
    add_op(CMD_I2F, 64'hFFFFFFFF_FFFFFFFF, 32'hFFFFFFFF);
    add_op(CMD_U2F, 64'hFFFFFFFF, 32'd0);
    add_op(CMD_F2I, 64'h3F7FFFFF, 32'd0);               // below one
    add_op(CMD_F2I, 64'hCF000001, 32'd0);               // negative saturate
    add_op(CMD_F2I, 64'h4F000000, 32'd0);               // positive saturate
    add_op(CMD_F2D, 64'h80000000, 32'd0);
    add_op(CMD_F2D, 64'h00000001, 32'd0);               // smallest subnormal
    add_op(CMD_F2D, 64'hFF812345, 32'd0);
    add_op(CMD_D2F, 64'h000FFFFF_FFFFFFFF, 32'd0);      // double subnormal
    add_op(CMD_D2F, 64'hFFFFFFFF_FFFFFFFF, 32'd0);
    add_op(CMD_D2F, 64'h47F00000_00000000, 32'd0);      // above float range
    add_op(CMD_EQ,  64'h00000000, 32'h80000000);        // +0 equals -0
    add_op(CMD_LT,  64'hBF800000, 32'h3F800000);
    add_op(CMD_LE,  64'h40000000, 32'h40000000);
    add_op(CMD_GT,  64'hC0000000, 32'hBF800000);
    add_op(CMD_GE,  64'h7F800000, 32'hFF800000);
    add_op(CMD_BAD_LO, 64'h12345678, 32'h1);
    add_op(CMD_BAD_HI, 64'hFFFFFFFF, 32'hFFFFFFFF);
    add_random_ops(110);
    // sender pauses until every expected result has come
    wait_drained();

    // receiver holds off while the sender keeps offering items
    hold_request = 1'b1;
    add_random_ops(20);
    wait (hold_cycles != 0);
    hold_request = 1'b0;

    src_idle_pct = 46;
    snk_idle_pct = 12;
    add_random_ops(120);
    wait_drained();

    src_idle_pct = 0;
    snk_idle_pct = 0;
    add_random_ops(130);
    wait_drained();

    if (mismatches == 0 && result_queue.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
